// ===== rtl/core/bspt_pkg.sv =====
// Shared widths, codes, handshake structs and helpers for the pointer tracker.
`timescale 1ns / 1ps

package bspt_pkg;

   // Field and datapath widths
   localparam int POS_W     = 16;                 // positions, bounds, deltas
   localparam int DIV_W     = 9;                  // signed divisor register
   localparam int MAG_W     = 9;                  // divisor magnitude, 1..256
   localparam int MCAND_W   = POS_W + 2;          // span or offset, signed
   localparam int PROD_W    = MCAND_W + MAG_W;    // span times magnitude, signed
   localparam int FINE_W    = 26;                 // fine-step accumulator, signed
   localparam int QUO_W     = 24;                 // clamped accumulator, unsigned
   localparam int REM_W     = MAG_W + 1;          // divider partial remainder
   localparam int CSR_IDX_W = 3;

   localparam int MUL_STEPS = MAG_W;              // one multiplier bit per cycle
   localparam int DIV_STEPS = QUO_W;              // one quotient bit per cycle

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_X_DIV  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y_DIV  = 3'd5;

   // Command and axis codes
   localparam logic CMD_MOVE   = 1'b0;
   localparam logic CMD_PRESET = 1'b1;
   localparam logic AXIS_X     = 1'b0;
   localparam logic AXIS_Y     = 1'b1;

   // Serial multiplier handshake
   typedef struct packed {
      logic               start;
      logic [MCAND_W-1:0] mcand;    // two's complement
      logic [MAG_W-1:0]   mplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;   // two's complement
   } mul_rsp_type;

   // Serial divider handshake
   typedef struct packed {
      logic             start;
      logic [QUO_W-1:0] dividend;
      logic [MAG_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   // Divisor magnitude: zero acts as one, -256 gives 256
   function automatic logic [MAG_W-1:0] div_magnitude(input logic [DIV_W-1:0] div);
      logic [MAG_W-1:0] mag;
      if (div == '0) begin
         mag = MAG_W'(1);
      end else if (div[DIV_W-1]) begin
         mag = ~div + MAG_W'(1);
      end else begin
         mag = div;
      end
      return mag;
   endfunction

endpackage

// ===== rtl/core/bspt_mul.sv =====
// Shift-add multiplier: signed multiplicand times unsigned factor, one bit a cycle.
`timescale 1ns / 1ps

module bspt_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  bspt_pkg::mul_req_type req,
   output bspt_pkg::mul_rsp_type rsp
);

   localparam int CNT_W = $clog2(bspt_pkg::MUL_STEPS);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [bspt_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [bspt_pkg::PROD_W-1:0]  mcand_ff, mcand_in;
   logic [bspt_pkg::MAG_W-1:0]   mplier_ff, mplier_in;

   // Load on start, then add the shifted multiplicand for each set factor bit
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (req.start) begin
         busy_in   = 1'b1;
         count_in  = '0;
         prod_in   = '0;
         mcand_in  = {{(bspt_pkg::PROD_W - bspt_pkg::MCAND_W){req.mcand[bspt_pkg::MCAND_W-1]}},
                      req.mcand};
         mplier_in = req.mplier;
      end else if (busy_ff) begin
         prod_in   = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(bspt_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = prod_ff;

endmodule

// ===== rtl/core/bspt_div.sv =====
// Restoring divider: unsigned dividend by unsigned divisor, one quotient bit a cycle.
`timescale 1ns / 1ps

module bspt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bspt_pkg::div_req_type req,
   output bspt_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(bspt_pkg::DIV_STEPS);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [bspt_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [bspt_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [bspt_pkg::MAG_W-1:0]   divisor_ff, divisor_in;
   logic [bspt_pkg::REM_W-1:0]   trial;
   logic                         fits;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff[bspt_pkg::REM_W-2:0], quo_ff[bspt_pkg::QUO_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quo_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial - {1'b0, divisor_ff} : trial;
         quo_in   = {quo_ff[bspt_pkg::QUO_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(bspt_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/bounded_scaled_pointer_tracker.sv =====
// Top level of the bounded scaled pointer tracker: registers, accumulators and sequencer.
`timescale 1ns / 1ps

// Tracks an X/Y pointer with one fine-step accumulator per axis. A move word adds
// (or, for a negative divisor, subtracts) its delta on one axis, clamps the
// accumulator to 0 .. (high-low+1)*|divisor|-1 and returns low + accumulator/|divisor|;
// a preset word loads both accumulators and returns nothing. Words are handled one at
// a time: a move goes through the serial multiplier that forms the clamp limit, the
// clamp step and the restoring divider, and waits to write its result while an earlier
// result has not been taken; a preset holds the input for two multiplier passes. A
// finished result sits in an output register, so the next word is taken while it waits.
module bounded_scaled_pointer_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic                                req_axis,
   input  logic signed [bspt_pkg::POS_W-1:0]   req_delta,
   input  logic signed [bspt_pkg::POS_W-1:0]   req_preset_x,
   input  logic signed [bspt_pkg::POS_W-1:0]   req_preset_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bspt_pkg::POS_W-1:0]   rsp_position,
   input  logic                                csr_write_en,
   input  logic [bspt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bspt_pkg::POS_W-1:0]          csr_write_data
);

   localparam int POS_W   = bspt_pkg::POS_W;
   localparam int DIV_W   = bspt_pkg::DIV_W;
   localparam int MAG_W   = bspt_pkg::MAG_W;
   localparam int MCAND_W = bspt_pkg::MCAND_W;
   localparam int PROD_W  = bspt_pkg::PROD_W;
   localparam int FINE_W  = bspt_pkg::FINE_W;
   localparam int QUO_W   = bspt_pkg::QUO_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLAMP,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                 state_ff, state_in;

   // Configuration
   logic [POS_W-1:0]          x_low_ff, x_low_in, x_high_ff, x_high_in;
   logic [POS_W-1:0]          y_low_ff, y_low_in, y_high_ff, y_high_in;
   logic [DIV_W-1:0]          x_div_ff, x_div_in, y_div_ff, y_div_in;

   // Accumulators and the word in flight
   logic [FINE_W-1:0]         fine_ff [2];
   logic [FINE_W-1:0]         fine_in [2];
   logic                      cmd_ff, cmd_in;
   logic                      axis_ff, axis_in;
   logic [POS_W-1:0]          preset_x_ff, preset_x_in, preset_y_ff, preset_y_in;
   logic [FINE_W-1:0]         acc_ff, acc_in;
   logic                      mul_start_ff, mul_start_in;
   logic                      div_start_ff, div_start_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]          rsp_position_ff, rsp_position_in;

   // Per-axis selections
   logic [MAG_W-1:0]          mag_sel;
   logic [POS_W-1:0]          low_sel, high_sel, preset_sel;
   logic [DIV_W-1:0]          req_div;
   logic [FINE_W-1:0]         delta_ext, moved_acc;
   logic [MCAND_W-1:0]        span, offset;
   logic signed [PROD_W-1:0]  prod, limit, acc_ext;
   logic [FINE_W-1:0]         clamped, preset_fine;

   bspt_pkg::mul_req_type     mul_req;
   bspt_pkg::mul_rsp_type     mul_rsp;
   bspt_pkg::div_req_type     div_req;
   bspt_pkg::div_rsp_type     div_rsp;

   assign low_sel    = (axis_ff == bspt_pkg::AXIS_X) ? x_low_ff    : y_low_ff;
   assign high_sel   = (axis_ff == bspt_pkg::AXIS_X) ? x_high_ff   : y_high_ff;
   assign preset_sel = (axis_ff == bspt_pkg::AXIS_X) ? preset_x_ff : preset_y_ff;
   assign mag_sel    = bspt_pkg::div_magnitude((axis_ff == bspt_pkg::AXIS_X) ? x_div_ff
                                                                              : y_div_ff);

   // Accumulator after the move, before clamping
   assign req_div   = (req_axis == bspt_pkg::AXIS_X) ? x_div_ff : y_div_ff;
   assign delta_ext = {{(FINE_W - POS_W){req_delta[POS_W-1]}}, req_delta};
   assign moved_acc = req_div[DIV_W-1] ? fine_ff[req_axis] - delta_ext
                                       : fine_ff[req_axis] + delta_ext;

   // Multiplicand: bound span for a move, preset offset for a preset
   assign span   = {{2{high_sel[POS_W-1]}}, high_sel} - {{2{low_sel[POS_W-1]}}, low_sel}
                   + MCAND_W'(1);
   assign offset = {{2{preset_sel[POS_W-1]}}, preset_sel} - {{2{low_sel[POS_W-1]}}, low_sel};

   assign mul_req.start  = mul_start_ff;
   assign mul_req.mcand  = (cmd_ff == bspt_pkg::CMD_PRESET) ? offset : span;
   assign mul_req.mplier = mag_sel;

   bspt_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // Clamp against the limit; preset value adds half a step
   assign prod        = $signed(mul_rsp.product);
   assign limit       = prod - PROD_W'(1);
   assign acc_ext     = $signed({{(PROD_W - FINE_W){acc_ff[FINE_W-1]}}, acc_ff});
   assign clamped     = (acc_ext < 0 || limit < 0) ? '0 :
                        (acc_ext > limit)          ? limit[FINE_W-1:0] : acc_ff;
   assign preset_fine = mul_rsp.product[FINE_W-1:0] + FINE_W'(mag_sel >> 1);

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = acc_ff[QUO_W-1:0];
   assign div_req.divisor  = mag_sel;

   bspt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer and register writes
   always_comb begin
      state_in        = state_ff;
      x_low_in        = x_low_ff;
      x_high_in       = x_high_ff;
      y_low_in        = y_low_ff;
      y_high_in       = y_high_ff;
      x_div_in        = x_div_ff;
      y_div_in        = y_div_ff;
      fine_in         = fine_ff;
      cmd_in          = cmd_ff;
      axis_in         = axis_ff;
      preset_x_in     = preset_x_ff;
      preset_y_in     = preset_y_ff;
      acc_in          = acc_ff;
      mul_start_in    = 1'b0;
      div_start_in    = 1'b0;
      rsp_valid_in    = rsp_valid_ff;
      rsp_position_in = rsp_position_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         case (csr_index)
            bspt_pkg::REG_X_LOW:  x_low_in  = csr_write_data;
            bspt_pkg::REG_X_HIGH: x_high_in = csr_write_data;
            bspt_pkg::REG_Y_LOW:  y_low_in  = csr_write_data;
            bspt_pkg::REG_Y_HIGH: y_high_in = csr_write_data;
            bspt_pkg::REG_X_DIV:  x_div_in  = csr_write_data[DIV_W-1:0];
            bspt_pkg::REG_Y_DIV:  y_div_in  = csr_write_data[DIV_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_cmd;
               axis_in      = (req_cmd == bspt_pkg::CMD_PRESET) ? bspt_pkg::AXIS_X : req_axis;
               preset_x_in  = req_preset_x;
               preset_y_in  = req_preset_y;
               acc_in       = moved_acc;
               mul_start_in = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               if (cmd_ff == bspt_pkg::CMD_PRESET) begin
                  fine_in[axis_ff] = preset_fine;
                  if (axis_ff == bspt_pkg::AXIS_X) begin
                     axis_in      = bspt_pkg::AXIS_Y;
                     mul_start_in = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_CLAMP;
               end
            end
         end
         ST_CLAMP: begin
            fine_in[axis_ff] = clamped;
            acc_in           = clamped;
            div_start_in     = 1'b1;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = low_sel + div_rsp.quotient[POS_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         x_low_ff        <= '0;
         x_high_ff       <= '0;
         y_low_ff        <= '0;
         y_high_ff       <= '0;
         x_div_ff        <= DIV_W'(1);
         y_div_ff        <= DIV_W'(1);
         fine_ff[0]      <= '0;
         fine_ff[1]      <= '0;
         cmd_ff          <= bspt_pkg::CMD_MOVE;
         axis_ff         <= bspt_pkg::AXIS_X;
         mul_start_ff    <= 1'b0;
         div_start_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         x_low_ff        <= x_low_in;
         x_high_ff       <= x_high_in;
         y_low_ff        <= y_low_in;
         y_high_ff       <= y_high_in;
         x_div_ff        <= x_div_in;
         y_div_ff        <= y_div_in;
         fine_ff[0]      <= fine_in[0];
         fine_ff[1]      <= fine_in[1];
         cmd_ff          <= cmd_in;
         axis_ff         <= axis_in;
         mul_start_ff    <= mul_start_in;
         div_start_ff    <= div_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_position_ff <= rsp_position_in;
   end

   // Word payload
   always_ff @(posedge clock) begin
      preset_x_ff <= preset_x_in;
      preset_y_ff <= preset_y_in;
      acc_ff      <= acc_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== rtl/core/bspt_checker.sv =====
// Port-level checks for the pointer tracker, bound to the top level.
`timescale 1ns / 1ps

module bspt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bspt_pkg::POS_W-1:0] rsp_position
);

   // A result word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_position))
      else $error("result position changed while stalled");

   // Words are processed one at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in flight");

   // No result can follow straight after taking a word with nothing pending
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared without any processing time");

   // A new result only comes from a word in flight
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the tracker was idle");

endmodule

bind bounded_scaled_pointer_tracker bspt_checker u_bspt_checker (.*);
